@@ hdl/dlmb_pkg.sv @@
package dlmb_pkg;

    localparam int LIMB_W     = 32;
    localparam int WORD_W     = 64;
    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS_LOW  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MODULUS_HIGH = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_BARRETT_LOW  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_BARRETT_HIGH = 3'd3;

    localparam logic [LIMB_W-1:0] MODULUS_LOW_RST  = 32'd268369921;
    localparam logic [LIMB_W-1:0] MODULUS_HIGH_RST = 32'd249561089;

    typedef struct packed {
        logic [WORD_W-1:0] left_word;
        logic [WORD_W-1:0] right_word;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] sum_low_raw;
        logic [WORD_W-1:0] sum_high_raw;
        logic [LIMB_W-1:0] sum_low_mod;
        logic [LIMB_W-1:0] sum_high_mod;
    } out_item_t;

    // limb products handed from the front end to the accumulator
    typedef struct packed {
        logic [WORD_W-1:0] prod_low;
        logic [WORD_W-1:0] prod_high;
        logic              last;
    } prod_item_t;

    typedef struct packed {
        logic [LIMB_W-1:0] modulus_low;
        logic [LIMB_W-1:0] modulus_high;
        logic [WORD_W-1:0] barrett_low;
        logic [WORD_W-1:0] barrett_high;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_RED,
        ST_OUT
    } back_state_t;

endpackage

@@ hdl/dlmb_front.sv @@
module dlmb_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dlmb_pkg::in_item_t     s_data,
    output logic                   q_valid,
    input  logic                   q_ready,
    output dlmb_pkg::prod_item_t   q_data
);
    import dlmb_pkg::*;

    prod_item_t front_reg, front_next;
    logic       front_valid_reg, front_valid_next;
    logic       accept;

    assign s_ready = !front_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = front_valid_reg;
    assign q_data  = front_reg;

    always_comb begin
        front_next = front_reg;
        if (accept) begin
            front_next.prod_low  = s_data.left_word[LIMB_W-1:0] * s_data.right_word[LIMB_W-1:0];
            front_next.prod_high = s_data.left_word[WORD_W-1:LIMB_W]
                                 * s_data.right_word[WORD_W-1:LIMB_W];
            front_next.last      = s_data.last;
        end
        if (accept) begin
            front_valid_next = 1'b1;
        end else if (q_ready) begin
            front_valid_next = 1'b0;
        end else begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        front_reg <= front_next;
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
    end

endmodule

@@ hdl/dlmb_queue.sv @@
module dlmb_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  dlmb_pkg::prod_item_t   in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output dlmb_pkg::prod_item_t   out_data
);
    import dlmb_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    prod_item_t        entries_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hdl/dlmb_back.sv @@
module dlmb_back (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  dlmb_pkg::cfg_t         cfg,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  dlmb_pkg::prod_item_t   q_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output dlmb_pkg::out_item_t    m_data
);
    import dlmb_pkg::*;

    // reduction sequence, one 32x32 partial product per multiply step, then a final correction
    localparam logic [2:0] STEP_LL  = 3'd0;
    localparam logic [2:0] STEP_LH  = 3'd1;
    localparam logic [2:0] STEP_HL  = 3'd2;
    localparam logic [2:0] STEP_HH  = 3'd3;
    localparam logic [2:0] STEP_QL  = 3'd4;
    localparam logic [2:0] STEP_QH  = 3'd5;
    localparam logic [2:0] STEP_FIX = 3'd6;

    back_state_t       state_reg, state_next;
    logic [2:0]        step_reg, step_next;
    logic              limb_reg, limb_next;
    logic [WORD_W-1:0] acc_low_reg, acc_low_next;
    logic [WORD_W-1:0] acc_high_reg, acc_high_next;
    logic [WORD_W-1:0] sum_low_reg, sum_low_next;
    logic [WORD_W-1:0] sum_high_reg, sum_high_next;
    logic [LIMB_W-1:0] mod_low_reg, mod_low_next;
    logic [LIMB_W-1:0] mod_high_reg, mod_high_next;
    logic [WORD_W+1:0] w_reg, w_next;       // column sum, holds q after HH
    logic [WORD_W-1:0] r_reg, r_next;
    out_item_t         out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    logic              pop;
    logic [WORD_W-1:0] new_low, new_high;
    logic [WORD_W-1:0] s_sel, b_sel;
    logic [LIMB_W-1:0] m_sel;
    logic [LIMB_W-1:0] mul_a, mul_b;
    logic [WORD_W-1:0] product;
    logic [WORD_W-1:0] r_fixed;

    assign q_ready = (state_reg == ST_ACC);
    assign pop     = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    assign new_low  = acc_low_reg + q_data.prod_low;
    assign new_high = acc_high_reg + q_data.prod_high;

    assign s_sel = limb_reg ? sum_high_reg : sum_low_reg;
    assign b_sel = limb_reg ? cfg.barrett_high : cfg.barrett_low;
    assign m_sel = limb_reg ? cfg.modulus_high : cfg.modulus_low;

    always_comb begin
        case (step_reg)
            STEP_LL: begin
                mul_a = s_sel[LIMB_W-1:0];
                mul_b = b_sel[LIMB_W-1:0];
            end
            STEP_LH: begin
                mul_a = s_sel[LIMB_W-1:0];
                mul_b = b_sel[WORD_W-1:LIMB_W];
            end
            STEP_HL: begin
                mul_a = s_sel[WORD_W-1:LIMB_W];
                mul_b = b_sel[LIMB_W-1:0];
            end
            STEP_HH: begin
                mul_a = s_sel[WORD_W-1:LIMB_W];
                mul_b = b_sel[WORD_W-1:LIMB_W];
            end
            STEP_QL: begin
                mul_a = w_reg[LIMB_W-1:0];
                mul_b = m_sel;
            end
            STEP_QH: begin
                mul_a = w_reg[WORD_W-1:LIMB_W];
                mul_b = m_sel;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign product = mul_a * mul_b;
    assign r_fixed = (r_reg >= {{LIMB_W{1'b0}}, m_sel}) ? r_reg - {{LIMB_W{1'b0}}, m_sel}
                                                         : r_reg;

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        limb_next      = limb_reg;
        acc_low_next   = acc_low_reg;
        acc_high_next  = acc_high_reg;
        sum_low_next   = sum_low_reg;
        sum_high_next  = sum_high_reg;
        mod_low_next   = mod_low_reg;
        mod_high_next  = mod_high_reg;
        w_next         = w_reg;
        r_next         = r_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;

        case (state_reg)
            ST_ACC: begin
                if (pop) begin
                    if (q_data.last) begin
                        sum_low_next  = new_low;
                        sum_high_next = new_high;
                        acc_low_next  = '0;
                        acc_high_next = '0;
                        step_next     = STEP_LL;
                        limb_next     = 1'b0;
                        state_next    = ST_RED;
                    end else begin
                        acc_low_next  = new_low;
                        acc_high_next = new_high;
                    end
                end
            end
            ST_RED: begin
                step_next = step_reg + 1'b1;
                case (step_reg)
                    // only the carry half of the low column feeds the middle sum
                    STEP_LL: w_next = (WORD_W + 2)'(product[WORD_W-1:LIMB_W]);
                    STEP_LH, STEP_HL: w_next = w_reg + (WORD_W + 2)'(product);
                    STEP_HH: w_next = (w_reg >> LIMB_W) + (WORD_W + 2)'(product);
                    STEP_QL: r_next = s_sel - product;
                    STEP_QH: r_next = r_reg - {product[LIMB_W-1:0], {LIMB_W{1'b0}}};
                    STEP_FIX: begin
                        step_next = STEP_LL;
                        if (limb_reg) begin
                            mod_high_next = r_fixed[LIMB_W-1:0];
                            state_next    = ST_OUT;
                        end else begin
                            mod_low_next = r_fixed[LIMB_W-1:0];
                            limb_next    = 1'b1;
                        end
                    end
                    default: step_next = STEP_LL;
                endcase
            end
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_next.sum_low_raw  = sum_low_reg;
                    out_next.sum_high_raw = sum_high_reg;
                    out_next.sum_low_mod  = mod_low_reg;
                    out_next.sum_high_mod = mod_high_reg;
                    out_valid_next        = 1'b1;
                    state_next            = ST_ACC;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge aclk) begin
        sum_low_reg  <= sum_low_next;
        sum_high_reg <= sum_high_next;
        mod_low_reg  <= mod_low_next;
        mod_high_reg <= mod_high_next;
        w_reg        <= w_next;
        r_reg        <= r_next;
        out_reg      <= out_next;
        if (!aresetn) begin
            state_reg     <= ST_ACC;
            step_reg      <= STEP_LL;
            limb_reg      <= 1'b0;
            acc_low_reg   <= '0;
            acc_high_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            limb_reg      <= limb_next;
            acc_low_reg   <= acc_low_next;
            acc_high_reg  <= acc_high_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RED) |-> (step_reg <= STEP_FIX))
        else $error("reduction step out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && q_data.last) |=> (acc_low_reg == '0 && acc_high_reg == '0))
        else $error("accumulators not cleared after last term");

    a_load_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside output state");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_valid_reg && !m_ready) |=> (state_reg == ST_OUT))
        else $error("pending result overwritten");

endmodule

@@ hdl/dual_limb_mac_barrett_unit.sv @@
// channel  | valid    | ready    | payload
// ---------+----------+----------+-----------------------------
// input    | s_valid  | s_ready  | s_data  (in_item_t)
// result   | m_valid  | m_ready  | m_data  (out_item_t)
// config   | cfg_wr_en| -        | cfg_addr, cfg_wdata
//
// Terms without last are added into the accumulators; a front register computes
// both limb products and a QUEUE_DEPTH-entry queue decouples it from the back end.
// A term with last holds the back end while both sums are reduced, in 7 steps per limb:
// one shared 32x32 multiplier for the Barrett quotient and q*m, then the final correction.
// Reset clears accumulators, queue, valid flags and barrett constants, loads default moduli.
// A stalled result sits in the output register while the front keeps filling the queue.
module dual_limb_mac_barrett_unit #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  dlmb_pkg::in_item_t                     s_data,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output dlmb_pkg::out_item_t                    m_data,
    input  logic                                   cfg_wr_en,
    input  logic [dlmb_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [dlmb_pkg::WORD_W-1:0]            cfg_wdata
);
    import dlmb_pkg::*;

    cfg_t       cfg_reg, cfg_next;
    logic       front_valid, front_ready;
    prod_item_t front_data;
    logic       back_valid, back_ready;
    prod_item_t back_data;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_MODULUS_LOW:  cfg_next.modulus_low  = cfg_wdata[LIMB_W-1:0];
                CFG_MODULUS_HIGH: cfg_next.modulus_high = cfg_wdata[LIMB_W-1:0];
                CFG_BARRETT_LOW:  cfg_next.barrett_low  = cfg_wdata;
                CFG_BARRETT_HIGH: cfg_next.barrett_high = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus_low  <= MODULUS_LOW_RST;
            cfg_reg.modulus_high <= MODULUS_HIGH_RST;
            cfg_reg.barrett_low  <= '0;
            cfg_reg.barrett_high <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    dlmb_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (front_valid),
        .q_ready (front_ready),
        .q_data  (front_data)
    );

    dlmb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_data  (back_data)
    );

    dlmb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (back_valid),
        .q_ready (back_ready),
        .q_data  (back_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
